FILE: src/acpr_pkg.sv
// shared constants, types and color helpers for the attribute cell pixel renderer
package acpr_pkg;

   localparam int SCREEN_DEPTH  = 16384;
   localparam int SCREEN_AW     = $clog2(SCREEN_DEPTH);
   localparam int PALETTE_DEPTH = 16;
   localparam int PALETTE_AW    = $clog2(PALETTE_DEPTH);
   localparam int RGB_W         = 24;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 2;
   localparam int PIXELS_PER_CELL = 8;
   localparam int PIX_CNT_W     = $clog2(PIXELS_PER_CELL);

   // transaction modes
   localparam logic [1:0] MODE_WRITE_SCREEN  = 2'd0;
   localparam logic [1:0] MODE_RENDER        = 2'd1;
   localparam logic [1:0] MODE_WRITE_PALETTE = 2'd2;

   // attribute_view codes, anything above checker acts as synthetic bitmap
   localparam logic [1:0] VIEW_NORMAL  = 2'd0;
   localparam logic [1:0] VIEW_CHECKER = 2'd1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_SWAP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTRIBUTE_VIEW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_BLEND    = 2'd2;

   localparam logic [12:0] ATTR_BASE     = 13'h1800;
   localparam logic [7:0]  SYNTH_PATTERN = 8'h3C;

   localparam logic [RGB_W-1:0] RGB_BLACK      = 24'h000000;
   localparam logic [RGB_W-1:0] RGB_GREY_DARK  = 24'h404040;
   localparam logic [RGB_W-1:0] RGB_GREY_LIGHT = 24'hC0C0C0;
   localparam logic [RGB_W-1:0] RGB_WHITE      = 24'hFFFFFF;

   typedef struct packed {
      logic       flash_cell;   // attribute bit 7
      logic       flash_phase;
      logic [2:0] paper_color;  // attribute bits 5..3
      logic       checker_odd;  // line bit 3 xor column bit 0
   } cell_ctl_type;

   function automatic logic [RGB_W-1:0] avg_rgb(input logic [RGB_W-1:0] a,
                                                input logic [RGB_W-1:0] b);
      logic [8:0] r_sum;
      logic [8:0] g_sum;
      logic [8:0] b_sum;
      r_sum = {1'b0, a[23:16]} + {1'b0, b[23:16]};
      g_sum = {1'b0, a[15:8]} + {1'b0, b[15:8]};
      b_sum = {1'b0, a[7:0]} + {1'b0, b[7:0]};
      return {r_sum[8:1], g_sum[8:1], b_sum[8:1]};
   endfunction

endpackage

FILE: src/acpr_if.sv
// request and pixel channel interfaces of the attribute cell pixel renderer
interface acpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        bank;
   logic [12:0] offset;
   logic [7:0]  data;
   logic [3:0]  palette_index;
   logic [23:0] palette_rgb;
   logic [7:0]  line;
   logic [4:0]  column;
   logic        shadow_screen;
   logic        flash_phase;

   modport source (output valid, mode, bank, offset, data, palette_index, palette_rgb,
                   line, column, shadow_screen, flash_phase, input ready);
   modport sink (input valid, mode, bank, offset, data, palette_index, palette_rgb,
                 line, column, shadow_screen, flash_phase, output ready);
endinterface

interface acpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last;

   modport source (output valid, red, green, blue, last, input ready);
   modport sink (input valid, red, green, blue, last, output ready);
endinterface

FILE: src/acpr_ram.sv
// generic ram, one write port and two registered read ports
module acpr_ram #(
   parameter int Depth = 16,
   parameter int Width = 8,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr_a,
   input  logic [AddrW-1:0] rd_addr_b,
   output logic [Width-1:0] rd_data_a,
   output logic [Width-1:0] rd_data_b
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

FILE: src/acpr_color_select.sv
// ink and paper color selection for one cell
module acpr_color_select import acpr_pkg::*; (
   input  logic [1:0]       attribute_view,
   input  logic             flash_blend,
   input  cell_ctl_type     ctl,
   input  logic [RGB_W-1:0] pal_ink,
   input  logic [RGB_W-1:0] pal_paper,
   output logic [RGB_W-1:0] ink_rgb,
   output logic [RGB_W-1:0] paper_rgb
);

   logic swap;

   assign swap = ctl.flash_cell && ctl.flash_phase;

   always_comb begin
      ink_rgb   = pal_ink;
      paper_rgb = pal_paper;
      case (attribute_view) inside
         VIEW_NORMAL: begin
            if (flash_blend) begin
               // pal_paper holds the non-bright entry of the paper color here
               ink_rgb   = (ctl.paper_color != 3'd0) ? avg_rgb(pal_ink, pal_paper) : pal_ink;
               paper_rgb = RGB_BLACK;
            end else if (swap) begin
               ink_rgb   = pal_paper;
               paper_rgb = pal_ink;
            end
         end
         VIEW_CHECKER: begin
            if (ctl.checker_odd) begin
               ink_rgb   = RGB_BLACK;
               paper_rgb = RGB_GREY_LIGHT;
            end else begin
               ink_rgb   = RGB_GREY_DARK;
               paper_rgb = RGB_WHITE;
            end
         end
         default: begin
            if (swap) begin
               ink_rgb   = pal_paper;
               paper_rgb = pal_ink;
            end
         end
      endcase
   end

endmodule

FILE: src/acpr_pixel_out.sv
// pixel serializer, shifts one cell out at one pixel per transaction
module acpr_pixel_out import acpr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic [7:0]       bitmap,
   input  logic [RGB_W-1:0] ink_rgb,
   input  logic [RGB_W-1:0] paper_rgb,
   output logic             can_load,
   acpr_rsp_if.source       rsp_chan
);

   logic                 valid_ff;
   logic [PIX_CNT_W-1:0] count_ff;
   logic [7:0]           shift_ff;
   logic [RGB_W-1:0]     ink_ff;
   logic [RGB_W-1:0]     paper_ff;
   logic [RGB_W-1:0]     pixel;
   logic                 last;
   logic                 fire;

   assign last     = (count_ff == PIX_CNT_W'(PIXELS_PER_CELL - 1));
   assign fire     = valid_ff && rsp_chan.ready;
   assign can_load = !valid_ff || (rsp_chan.ready && last);
   assign pixel    = shift_ff[7] ? ink_ff : paper_ff;

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.red   = pixel[23:16];
   assign rsp_chan.green = pixel[15:8];
   assign rsp_chan.blue  = pixel[7:0];
   assign rsp_chan.last  = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         count_ff <= '0;
      end else if (fire) begin
         if (last) begin
            valid_ff <= 1'b0;
         end
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff <= bitmap;
         ink_ff   <= ink_rgb;
         paper_ff <= paper_rgb;
      end else if (fire) begin
         shift_ff <= {shift_ff[6:0], 1'b0};
      end
   end

   a_count_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> valid_ff)
      else $error("pixel count advanced with no cell in flight");

endmodule

FILE: src/attribute_cell_pixel_renderer_core.sv
// top level of the attribute cell pixel renderer
//
// a render transaction turns one 8-pixel character cell into eight pixel
// transactions, one per clock while rsp_chan.ready is high, bitmap msb
// first, last set on the eighth; the serializer loads the next cell as the
// last pixel of the current one is taken, and screen and palette writes are
// taken one per cycle unless the front is stalled. flow: the accept edge
// reads bitmap and attribute bytes from the screen ram (interleaved
// addressing, bank = shadow_screen xor screen_swap), the attribute then
// addresses two palette entries, and the palette data then loads the
// serializer. the front stages keep taking transactions while the serializer
// still shows a cell; the whole front stalls only when a finished cell waits
// for the serializer. screen and palette contents are undefined until written.
module attribute_cell_pixel_renderer_core import acpr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   acpr_req_if.sink               req_chan,
   acpr_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic       screen_swap_ff;
   logic [1:0] attribute_view_ff;
   logic       flash_blend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_swap_ff    <= 1'b0;
         attribute_view_ff <= VIEW_NORMAL;
         flash_blend_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_SWAP:    screen_swap_ff    <= csr_wdata[0];
            CSR_ATTRIBUTE_VIEW: attribute_view_ff <= csr_wdata[1:0];
            CSR_FLASH_BLEND:    flash_blend_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // global advance: everything moves unless a finished cell waits
   logic adv;
   logic accept;
   logic out_can_load;
   logic s1_valid_ff;
   logic s2_valid_ff;

   assign adv            = !s2_valid_ff || out_can_load;
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;

   // stage 0: address forming and screen ram access
   logic                 scr_wr;
   logic                 pal_wr;
   logic                 disp_bank;
   logic [SCREEN_AW-1:0] bmp_addr;
   logic [SCREEN_AW-1:0] attr_addr;
   logic [7:0]           scr_bitmap;
   logic [7:0]           scr_attr;

   assign scr_wr    = accept && (req_chan.mode == MODE_WRITE_SCREEN);
   assign pal_wr    = accept && (req_chan.mode == MODE_WRITE_PALETTE);
   assign disp_bank = req_chan.shadow_screen ^ screen_swap_ff;

   // third-of-screen, pixel row, character row, column: disjoint bit fields
   assign bmp_addr  = {disp_bank, req_chan.line[7:6], req_chan.line[2:0],
                       req_chan.line[5:3], req_chan.column};
   // attribute area sits above the bitmap, one byte per 8x8 cell
   assign attr_addr = {disp_bank, ATTR_BASE | {3'b000, req_chan.line[7:3], req_chan.column}};

   acpr_ram #(.Depth(SCREEN_DEPTH), .Width(8)) u_screen_ram (
      .clock     (clock),
      .wr_en     (scr_wr),
      .wr_addr   ({req_chan.bank, req_chan.offset}),
      .wr_data   (req_chan.data),
      .rd_en     (adv),
      .rd_addr_a (bmp_addr),
      .rd_addr_b (attr_addr),
      .rd_data_a (scr_bitmap),
      .rd_data_b (scr_attr)
   );

   // stage 1 registers travel beside the screen ram read data
   logic [7:0] s1_line_ff;
   logic       s1_column0_ff;
   logic       s1_flash_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept && (req_chan.mode == MODE_RENDER);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_line_ff        <= req_chan.line;
         s1_column0_ff     <= req_chan.column[0];
         s1_flash_phase_ff <= req_chan.flash_phase;
      end
   end

   // stage 1: attribute decode, bitmap choice, palette access
   logic [7:0]            synth_bitmap;
   logic [7:0]            s1_bitmap;
   logic [PALETTE_AW-1:0] pal_addr_ink;
   logic [PALETTE_AW-1:0] pal_addr_paper;
   logic [RGB_W-1:0]      pal_ink;
   logic [RGB_W-1:0]      pal_paper;
   cell_ctl_type          s1_ctl;

   always_comb begin
      // synthetic bitmap: blank on the outer line pairs of each cell row
      case (s1_line_ff[2:1]) inside
         2'b01, 2'b10: synth_bitmap = SYNTH_PATTERN;
         default:      synth_bitmap = 8'h00;
      endcase
      case (attribute_view_ff) inside
         VIEW_NORMAL, VIEW_CHECKER: s1_bitmap = scr_bitmap;
         default:                   s1_bitmap = synth_bitmap;
      endcase
   end

   assign pal_addr_ink   = {scr_attr[6], scr_attr[2:0]};
   // blend averages with the non-bright paper entry
   assign pal_addr_paper = ((attribute_view_ff == VIEW_NORMAL) && flash_blend_ff) ?
                           {1'b0, scr_attr[5:3]} : {scr_attr[6], scr_attr[5:3]};

   assign s1_ctl.flash_cell  = scr_attr[7];
   assign s1_ctl.flash_phase = s1_flash_phase_ff;
   assign s1_ctl.paper_color = scr_attr[5:3];
   assign s1_ctl.checker_odd = s1_line_ff[3] ^ s1_column0_ff;

   acpr_ram #(.Depth(PALETTE_DEPTH), .Width(RGB_W)) u_palette_ram (
      .clock     (clock),
      .wr_en     (pal_wr),
      .wr_addr   (req_chan.palette_index),
      .wr_data   (req_chan.palette_rgb),
      .rd_en     (adv),
      .rd_addr_a (pal_addr_ink),
      .rd_addr_b (pal_addr_paper),
      .rd_data_a (pal_ink),
      .rd_data_b (pal_paper)
   );

   // stage 2 registers
   logic [7:0]   s2_bitmap_ff;
   cell_ctl_type s2_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_bitmap_ff <= s1_bitmap;
         s2_ctl_ff    <= s1_ctl;
      end
   end

   // stage 2: final ink and paper colors into the serializer
   logic [RGB_W-1:0] ink_rgb;
   logic [RGB_W-1:0] paper_rgb;

   acpr_color_select u_color_select (
      .attribute_view (attribute_view_ff),
      .flash_blend    (flash_blend_ff),
      .ctl            (s2_ctl_ff),
      .pal_ink        (pal_ink),
      .pal_paper      (pal_paper),
      .ink_rgb        (ink_rgb),
      .paper_rgb      (paper_rgb)
   );

   acpr_pixel_out u_pixel_out (
      .clock     (clock),
      .reset     (reset),
      .load      (s2_valid_ff && out_can_load),
      .bitmap    (s2_bitmap_ff),
      .ink_rgb   (ink_rgb),
      .paper_rgb (paper_rgb),
      .can_load  (out_can_load),
      .rsp_chan  (rsp_chan)
   );

   a_stall_only_on_waiting_cell: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s2_valid_ff && rsp_chan.valid))
      else $error("input stalled with no finished cell waiting");

   a_cell_pixels_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=> rsp_chan.valid)
      else $error("pixel transactions of a cell broke off before the last pixel");

   a_render_moves_forward: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv) |=> s2_valid_ff)
      else $error("render cell lost between palette read and color stage");

   a_write_makes_no_cell: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.mode != MODE_RENDER)) |=> !s1_valid_ff)
      else $error("write transaction started a render cell");

endmodule
